// File: design/dod_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dod_pkg
// Shared types and constants for the delta-of-delta encoder.
// ---------------------------------------------------------------------------
package dod_pkg;

  localparam int unsigned SampleW = 64;
  localparam int unsigned MagW    = 63;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_FIRST = 2'd0,
    KIND_DELTA = 2'd1,
    KIND_DOD   = 2'd2
  } kind_t;

  // Position within a block
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_DOD    = 2'd2
  } phase_t;

  // Prefix codes, right-aligned
  localparam logic [4:0] PFX_ZERO = 5'b00000;
  localparam logic [4:0] PFX_6    = 5'b00010;
  localparam logic [4:0] PFX_8    = 5'b00110;
  localparam logic [4:0] PFX_11   = 5'b01110;
  localparam logic [4:0] PFX_31   = 5'b11110;
  localparam logic [4:0] PFX_63   = 5'b11111;

  // Exclusive range limits of the delta of deltas
  localparam logic signed [SampleW-1:0] LIM6_LO  = -64'sd63;
  localparam logic signed [SampleW-1:0] LIM6_HI  = 64'sd64;
  localparam logic signed [SampleW-1:0] LIM8_LO  = -64'sd255;
  localparam logic signed [SampleW-1:0] LIM8_HI  = 64'sd256;
  localparam logic signed [SampleW-1:0] LIM11_LO = -64'sd2047;
  localparam logic signed [SampleW-1:0] LIM11_HI = 64'sd2048;
  localparam logic signed [SampleW-1:0] LIM31_LO = -64'sd2147483648;
  localparam logic signed [SampleW-1:0] LIM31_HI = 64'sd2147483647;

  // One delta-of-delta code
  typedef struct packed {
    logic [4:0]      prefix_code;
    logic [2:0]      prefix_len;
    logic            sign_bit;
    logic [MagW-1:0] magnitude;
    logic [5:0]      magnitude_len;
  } code_t;

endpackage
`default_nettype wire

// File: design/dod_code.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dod_code
// Combinational code selection for one delta of deltas: prefix, sign and
// magnitude field, chosen by signed range.
// ---------------------------------------------------------------------------
module dod_code (
  input  wire logic signed [dod_pkg::SampleW-1:0] dd,
  output dod_pkg::code_t                          code
);
  import dod_pkg::*;

  logic neg;
  logic [MagW-1:0] mag;

  // |dd| - 1: for negative dd this is simply ~dd
  assign neg = dd[SampleW-1];
  always_comb begin
    logic [SampleW-1:0] dec;
    dec = dd - 64'sd1;
    mag = neg ? ~dd[MagW-1:0] : dec[MagW-1:0];
  end

  // Range select
  always_comb begin
    code = '0;
    if (dd == '0) begin
      code.prefix_code = PFX_ZERO;
      code.prefix_len  = 3'd1;
    end else begin
      code.sign_bit  = neg;
      code.magnitude = mag;
      if (dd > LIM6_LO && dd < LIM6_HI) begin
        code.prefix_code   = PFX_6;
        code.prefix_len    = 3'd2;
        code.magnitude_len = 6'd6;
      end else if (dd > LIM8_LO && dd < LIM8_HI) begin
        code.prefix_code   = PFX_8;
        code.prefix_len    = 3'd3;
        code.magnitude_len = 6'd8;
      end else if (dd > LIM11_LO && dd < LIM11_HI) begin
        code.prefix_code   = PFX_11;
        code.prefix_len    = 3'd4;
        code.magnitude_len = 6'd11;
      end else if (dd > LIM31_LO && dd < LIM31_HI) begin
        code.prefix_code   = PFX_31;
        code.prefix_len    = 3'd5;
        code.magnitude_len = 6'd31;
      end else begin
        code.prefix_code   = PFX_63;
        code.prefix_len    = 3'd5;
        code.magnitude_len = 6'd63;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/delta_of_delta_encoder.sv
`default_nettype none
// ---------------------------------------------------------------------------
// delta_of_delta_encoder
// Streaming delta-of-delta encoder for 64-bit samples, one result per sample.
// ---------------------------------------------------------------------------
// Each accepted sample yields exactly one result transaction: the first
// sample of a block (block_start, or the first after reset) comes out raw,
// the second as its raw delta, and every later one as a prefix/sign/magnitude
// code for the delta of deltas. The block takes one sample per cycle unless
// code_stall backs up the output register, and loads each result into the output
// register as its sample leaves the input register; that rate is set by the loop
// through last_value/last_delta, which updates as each sample leaves the input
// register. A result waiting on code_stall holds the output register while one
// further sample may still enter the input register.
module delta_of_delta_encoder (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample channel
  input  wire logic                                sample_valid,
  output      logic                                sample_stall,
  input  wire logic                                block_start,
  input  wire logic signed [dod_pkg::SampleW-1:0]  sample,
  // code channel
  output      logic                                code_valid,
  input  wire logic                                code_stall,
  output      logic [1:0]                          kind,
  output      logic signed [dod_pkg::SampleW-1:0]  raw_word,
  output      logic [4:0]                          prefix_code,
  output      logic [2:0]                          prefix_len,
  output      logic                                sign_bit,
  output      logic [dod_pkg::MagW-1:0]            magnitude,
  output      logic [5:0]                          magnitude_len
);
  import dod_pkg::*;

  // Pipeline control
  logic out_en;
  logic s1_en;
  logic s2_load;
  logic s1_valid;
  logic s1_start;
  logic signed [SampleW-1:0] s1_sample;

  assign out_en       = !code_valid || !code_stall;
  assign s1_en        = !s1_valid || out_en;
  assign s2_load      = s1_valid && out_en;
  assign sample_stall = !s1_en;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_start  <= block_start;
      s1_sample <= sample;
    end
  end

  // Encoder state
  phase_t phase, phase_next;
  logic signed [SampleW-1:0] last_value;
  logic signed [SampleW-1:0] last_delta, last_delta_next;
  logic signed [SampleW-1:0] delta, dd;
  code_t dd_code;

  assign delta = s1_sample - last_value;
  assign dd    = delta - last_delta;

  dod_code u_code (
    .dd   (dd),
    .code (dd_code)
  );

  // Next state and result selection
  kind_t kind_next;
  logic signed [SampleW-1:0] raw_next;
  code_t code_next;

  always_comb begin
    phase_next      = phase;
    last_delta_next = delta;
    kind_next       = KIND_DOD;
    raw_next        = '0;
    code_next       = dd_code;
    if (s1_start || phase == PH_FIRST) begin
      phase_next      = PH_SECOND;
      last_delta_next = '0;
      kind_next       = KIND_FIRST;
      raw_next        = s1_sample;
      code_next       = '0;
    end else begin
      unique case (phase)
        PH_SECOND: begin
          phase_next = PH_DOD;
          kind_next  = KIND_DELTA;
          raw_next   = delta;
          code_next  = '0;
        end
        default: begin
          phase_next = PH_DOD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIRST;
      last_value <= '0;
      last_delta <= '0;
    end else if (s2_load) begin
      phase      <= phase_next;
      last_value <= s1_sample;
      last_delta <= last_delta_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (out_en) begin
      code_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      kind          <= kind_next;
      raw_word      <= raw_next;
      prefix_code   <= code_next.prefix_code;
      prefix_len    <= code_next.prefix_len;
      sign_bit      <= code_next.sign_bit;
      magnitude     <= code_next.magnitude;
      magnitude_len <= code_next.magnitude_len;
    end
  end

  // Checks
  a_start_gives_first: assert property (@(posedge clk) disable iff (rst)
    s2_load && s1_start |=> code_valid && kind == KIND_FIRST)
    else $error("block start did not produce a raw first value");

  a_raw_no_code: assert property (@(posedge clk) disable iff (rst)
    code_valid && kind != KIND_DOD |-> prefix_len == 3'd0 && magnitude_len == 6'd0)
    else $error("raw result carries a code");

  a_zero_no_mag: assert property (@(posedge clk) disable iff (rst)
    code_valid && kind == KIND_DOD && prefix_len == 3'd1 |->
      magnitude_len == 6'd0 && raw_word == '0)
    else $error("zero delta of deltas carries a magnitude");

  a_short_mag_fits: assert property (@(posedge clk) disable iff (rst)
    code_valid && magnitude_len == 6'd6 |-> magnitude[MagW-1:6] == '0)
    else $error("6-bit magnitude out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> s1_valid && code_valid && code_stall)
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

// File: verif/delta_of_delta_encoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// delta_of_delta_encoder_tb
// Self-checking testbench for the streaming delta-of-delta encoder.
// ---------------------------------------------------------------------------
// A local encoder model predicts one code per accepted sample and queues it.
// A monitor pops and compares every field of each code transaction. Stimulus
// runs directed corner cases (missing block start, sample extremes, every
// range edge of the delta of deltas), then random blocks aimed at each code
// class with noise mixed in, then a long receiver hold that backs up the
// input. Both sides insert random idle cycles, with some stretches at full
// rate.
// ---------------------------------------------------------------------------
module delta_of_delta_encoder_tb;
  import dod_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumEdges   = 19;
  localparam int unsigned HoldCycles = 300;

  // One expected code transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] raw_word;
    code_t       code;
  } dod_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic                       block_start = 1'b0;
  logic signed [SampleW-1:0]  sample = '0;
  logic                       code_valid;
  logic                       code_stall = 1'b0;
  logic [1:0]                 kind;
  logic signed [SampleW-1:0]  raw_word;
  logic [4:0]                 prefix_code;
  logic [2:0]                 prefix_len;
  logic                       sign_bit;
  logic [MagW-1:0]            magnitude;
  logic [5:0]                 magnitude_len;

  delta_of_delta_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .block_start  (block_start),
    .sample       (sample),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .kind         (kind),
    .raw_word     (raw_word),
    .prefix_code  (prefix_code),
    .prefix_len   (prefix_len),
    .sign_bit     (sign_bit),
    .magnitude    (magnitude),
    .magnitude_len(magnitude_len)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Encoder model state
  logic [63:0] enc_last_value = '0;
  logic [63:0] enc_last_delta = '0;
  phase_t      enc_phase      = PH_FIRST;

  dod_result_t pending_codes[$];

  int unsigned mismatches   = 0;
  int unsigned samples_sent = 0;
  int unsigned codes_seen   = 0;
  int unsigned wide_codes   = 0;
  int unsigned zero_codes   = 0;
  int unsigned cycle_count  = 0;

  // Idle controls, set by the test tasks
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_go    = 1'b0;
  bit          hold_seen  = 1'b0;
  int unsigned rx_wait    = 0;
  int unsigned rx_gap;

  // Model: one sample in, one code out, state updated
  function automatic dod_result_t encode_sample(logic start, logic [63:0] s);
    dod_result_t       r;
    logic [63:0]       delta;
    logic [63:0]       dd;
    logic [63:0]       absval;
    logic [63:0]       mag_full;
    logic signed [63:0] v;
    r = '0;
    if (start || enc_phase == PH_FIRST) begin
      enc_last_value = s;
      enc_last_delta = '0;
      enc_phase      = PH_SECOND;
      r.kind         = KIND_FIRST;
      r.raw_word     = s;
      return r;
    end
    delta = s - enc_last_value;
    if (enc_phase == PH_SECOND) begin
      enc_last_value = s;
      enc_last_delta = delta;
      enc_phase      = PH_DOD;
      r.kind         = KIND_DELTA;
      r.raw_word     = delta;
      return r;
    end
    dd = delta - enc_last_delta;
    enc_last_value = s;
    enc_last_delta = delta;
    r.kind = KIND_DOD;
    if (dd == 64'd0) begin
      r.code.prefix_code = PFX_ZERO;
      r.code.prefix_len  = 3'd1;
      return r;
    end
    v = dd;
    // most negative dd wraps to 2^63, giving an all-ones magnitude
    absval   = v[63] ? (64'd0 - dd) : dd;
    mag_full = absval - 64'd1;
    r.code.sign_bit  = v[63];
    r.code.magnitude = mag_full[MagW-1:0];
    if (v > LIM6_LO && v < LIM6_HI) begin
      r.code.prefix_code = PFX_6;  r.code.prefix_len = 3'd2; r.code.magnitude_len = 6'd6;
    end else if (v > LIM8_LO && v < LIM8_HI) begin
      r.code.prefix_code = PFX_8;  r.code.prefix_len = 3'd3; r.code.magnitude_len = 6'd8;
    end else if (v > LIM11_LO && v < LIM11_HI) begin
      r.code.prefix_code = PFX_11; r.code.prefix_len = 3'd4; r.code.magnitude_len = 6'd11;
    end else if (v > LIM31_LO && v < LIM31_HI) begin
      r.code.prefix_code = PFX_31; r.code.prefix_len = 3'd5; r.code.magnitude_len = 6'd31;
    end else begin
      r.code.prefix_code = PFX_63; r.code.prefix_len = 3'd5; r.code.magnitude_len = 6'd63;
    end
    return r;
  endfunction

  // Range edges of the delta of deltas, both sides of each limit
  function automatic logic [63:0] boundary_dd(int unsigned idx);
    case (idx)
      0:       boundary_dd = 64'h8000_0000_0000_0000;
      1:       boundary_dd = 64'h7FFF_FFFF_FFFF_FFFF;
      2:       boundary_dd = 64'd0;
      3:       boundary_dd = -64'sd62;
      4:       boundary_dd = -64'sd63;
      5:       boundary_dd = 64'd63;
      6:       boundary_dd = 64'd64;
      7:       boundary_dd = -64'sd254;
      8:       boundary_dd = -64'sd255;
      9:       boundary_dd = 64'd255;
      10:      boundary_dd = 64'd256;
      11:      boundary_dd = -64'sd2046;
      12:      boundary_dd = -64'sd2047;
      13:      boundary_dd = 64'd2047;
      14:      boundary_dd = 64'd2048;
      15:      boundary_dd = 64'hFFFF_FFFF_8000_0001;
      16:      boundary_dd = 64'hFFFF_FFFF_8000_0000;
      17:      boundary_dd = 64'h0000_0000_7FFF_FFFE;
      default: boundary_dd = 64'h0000_0000_7FFF_FFFF;
    endcase
  endfunction

  // Random delta of deltas spread over every code class
  function automatic logic [63:0] pick_dd();
    logic [63:0] m;
    bit          neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       m = 64'($urandom_range(64, 255));
      2:       m = 64'($urandom_range(256, 2047));
      3:       m = 64'($urandom_range(2048, 32'h8000_0001));
      4:       m = {$urandom, $urandom} >> $urandom_range(0, 32);
      5:       return {$urandom, $urandom};
      6, 7:    return boundary_dd($urandom_range(0, NumEdges - 1));
      default: m = 64'($urandom_range(1, 63));
    endcase
    return neg ? (64'd0 - m) : m;
  endfunction

  // Next sample that produces the wanted delta of deltas
  function automatic logic [63:0] sample_for_dd(logic [63:0] dd);
    return enc_last_value + enc_last_delta + dd;
  endfunction

  // Offer one sample, hold it until accepted, queue its expected code
  task automatic send_sample(input logic start, input logic [63:0] s);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    block_start  <= start;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pending_codes.push_back(encode_sample(start, s));
    samples_sent++;
  endtask

  // Drop valid and wait for every queued code to come back
  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  // Samples without a block start right after reset, sample extremes,
  // and restarts from the second and delta-of-delta phases
  task automatic test_missing_start_and_extremes();
    send_sample(1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_sample(1'b0, 64'h8000_0000_0000_0000);
    send_sample(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(1'b1, 64'h0000_0000_0000_0000);
    send_sample(1'b1, 64'h8000_0000_0000_0000);
    send_sample(1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  // Walk every range edge of the delta of deltas
  task automatic test_range_edges();
    send_sample(1'b1, {$urandom, $urandom});
    send_sample(1'b0, {$urandom, $urandom});
    for (int unsigned i = 0; i < NumEdges; i++) begin
      send_sample(1'b0, sample_for_dd(boundary_dd(i)));
    end
  endtask

  // Random blocks: mostly well-formed, some pure noise
  task automatic test_random_blocks(input int unsigned n_items);
    int unsigned sent;
    int unsigned blen;
    bit          noisy;
    sent = 0;
    while (sent < n_items) begin
      blen       = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      noisy      = ($urandom_range(0, 9) == 0);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      send_sample(1'b1, {$urandom, $urandom});
      sent++;
      for (int unsigned i = 1; i < blen && sent < n_items; i++) begin
        if (noisy) begin
          send_sample(($urandom_range(0, 7) == 0), {$urandom, $urandom});
        end else if (enc_phase == PH_DOD) begin
          send_sample(1'b0, sample_for_dd(pick_dd()));
        end else begin
          send_sample(1'b0, {$urandom, $urandom});
        end
        sent++;
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver holds off for a long stretch while the sender keeps going
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_go    = ~hold_go;
    send_sample(1'b1, {$urandom, $urandom});
    for (int unsigned i = 0; i < 29; i++) begin
      if (enc_phase == PH_DOD) send_sample(1'b0, sample_for_dd(pick_dd()));
      else                     send_sample(1'b0, {$urandom, $urandom});
    end
    tx_idle_en = 1'b1;
    // sender pauses until the backlog is gone
    wait_drained();
    for (int unsigned i = 0; i < 8; i++) begin
      send_sample(1'b0, sample_for_dd(pick_dd()));
    end
  endtask

  // Receiver stall: per-transaction random wait, or a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      code_stall <= 1'b0;
      rx_wait    <= 0;
    end else if (hold_go != hold_seen) begin
      hold_seen  <= hold_go;
      rx_wait    <= HoldCycles;
      code_stall <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait    <= rx_wait - 1;
      code_stall <= (rx_wait != 1);
    end else if (code_valid && !code_stall) begin
      rx_gap     = rx_idle_en ? $urandom_range(0, 12) : 0;
      rx_wait    <= rx_gap;
      code_stall <= (rx_gap != 0);
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: each accepted code against the oldest expectation
  always @(posedge clk) begin
    dod_result_t want;
    if (!rst && code_valid && !code_stall) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected code transaction, kind %h raw %h", $time, kind, raw_word);
        mismatches++;
      end else begin
        want = pending_codes.pop_front();
        codes_seen++;
        if (want.kind == KIND_DOD && want.code.magnitude_len == 6'd63) wide_codes++;
        if (want.kind == KIND_DOD && want.code.prefix_code == PFX_ZERO) zero_codes++;
        compare_field("kind",          64'(want.kind),               64'(kind));
        compare_field("raw_word",      want.raw_word,                raw_word);
        compare_field("prefix_code",   64'(want.code.prefix_code),   64'(prefix_code));
        compare_field("prefix_len",    64'(want.code.prefix_len),    64'(prefix_len));
        compare_field("sign_bit",      64'(want.code.sign_bit),      64'(sign_bit));
        compare_field("magnitude",     64'(want.code.magnitude),     64'(magnitude));
        compare_field("magnitude_len", 64'(want.code.magnitude_len), 64'(magnitude_len));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d codes outstanding",
               cycle_count, pending_codes.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_missing_start_and_extremes();
    test_range_edges();
    test_random_blocks(640);
    test_backpressure();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d samples and %0d codes (%0d zero, %0d 63-bit),",
             samples_sent, codes_seen, zero_codes, wide_codes);
    $display("with range edges, restarts, noise and a %0d-cycle receiver hold", HoldCycles);
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/dod_pkg.sv
design/dod_code.sv
design/delta_of_delta_encoder.sv
verif/delta_of_delta_encoder_tb.sv
